FILE: src/ricf16_pkg.sv
// Package for the record image checker: running state record, phase and status codes.
// Shared by ricf16_step and record_image_checker_fletcher16_core. No dependencies.
package ricf16_pkg;

    localparam int unsigned IMAGE_MAX_BYTES_DEF = 256;
    localparam logic [8:0]  FLETCHER_MOD        = 9'd255;
    localparam int unsigned BYTE_BITS           = 8;
    localparam int unsigned HEADER_BYTES        = 4;
    localparam int unsigned REC_W               = 7;
    localparam logic [REC_W-1:0] RECORDS_MAX    = 7'd127;
    localparam int unsigned STATUS_W            = 2;
    localparam int unsigned CHECKSUM_W          = 2 * BYTE_BITS;

    // Where the next byte lands in the record framing.
    typedef enum logic [2:0] {
        PH_IDX_HI = 3'd0,
        PH_IDX_LO = 3'd1,
        PH_SUBIDX = 3'd2,
        PH_LEN    = 3'd3,
        PH_DATA   = 3'd4
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_TRUNC_HDR  = 2'd1,
        ST_TRUNC_DATA = 2'd2,
        ST_TOO_LONG   = 2'd3
    } t_status;

    // Running state except the byte counter, whose width follows the image size.
    typedef struct packed {
        logic [BYTE_BITS-1:0] low_sum;
        logic [BYTE_BITS-1:0] high_sum;
        t_phase               phase;
        logic [BYTE_BITS-1:0] data_remaining;
        logic [REC_W-1:0]     records_seen;
        logic                 overflow;
    } t_state;

    localparam t_state STATE_RESET = '{
        low_sum: '0, high_sum: '0, phase: PH_IDX_HI,
        data_remaining: '0, records_seen: '0, overflow: 1'b0
    };

    // Add modulo 255 with a single conditional subtract; first operand below 255, second at most 255.
    function automatic logic [BYTE_BITS-1:0] mod_add(
        input logic [BYTE_BITS-1:0] a,
        input logic [BYTE_BITS-1:0] b
    );
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= FLETCHER_MOD) begin
            s = s - FLETCHER_MOD;
        end
        return s[BYTE_BITS-1:0];
    endfunction

endpackage

FILE: src/ricf16_step.sv
// One-byte update of the checker state: Fletcher sums, record framing, counters, status.
// Pure combinational; depends on ricf16_pkg.
module ricf16_step #(
    parameter int unsigned IMAGE_MAX_BYTES = ricf16_pkg::IMAGE_MAX_BYTES_DEF,
    parameter int unsigned LEN_W           = $clog2(IMAGE_MAX_BYTES + 1)
) (
    input  ricf16_pkg::t_state  i_state,
    input  logic [LEN_W-1:0]    i_cnt,
    input  logic [7:0]          i_byte,
    output ricf16_pkg::t_state  o_state,
    output logic [LEN_W-1:0]    o_cnt,
    output ricf16_pkg::t_status o_status
);
    import ricf16_pkg::*;

    localparam logic [LEN_W-1:0] CNT_MAX = LEN_W'(IMAGE_MAX_BYTES);

    logic [BYTE_BITS-1:0] low_new;
    logic [BYTE_BITS-1:0] rem_dec;

    assign low_new = mod_add(i_state.low_sum, i_byte);
    assign rem_dec = (i_state.data_remaining != '0) ? i_state.data_remaining - 8'd1
                                                   : i_state.data_remaining;

    always_comb begin
        o_state          = i_state;
        o_state.low_sum  = low_new;
        o_state.high_sum = mod_add(i_state.high_sum, low_new);
        o_cnt            = i_cnt;

        if (i_cnt < CNT_MAX) begin
            o_cnt = i_cnt + LEN_W'(1);
        end else begin
            o_state.overflow = 1'b1;
        end

        case (i_state.phase)
            PH_IDX_HI: begin
                if (i_state.records_seen < RECORDS_MAX) begin
                    o_state.records_seen = i_state.records_seen + REC_W'(1);
                end
                o_state.phase = PH_IDX_LO;
            end
            PH_IDX_LO: o_state.phase = PH_SUBIDX;
            PH_SUBIDX: o_state.phase = PH_LEN;
            PH_LEN: begin
                o_state.data_remaining = i_byte;
                o_state.phase          = (i_byte == '0) ? PH_IDX_HI : PH_DATA;
            end
            default: begin
                // data byte
                o_state.data_remaining = rem_dec;
                o_state.phase          = (rem_dec == '0) ? PH_IDX_HI : PH_DATA;
            end
        endcase

        if (o_state.overflow) begin
            o_status = ST_TOO_LONG;
        end else begin
            case (o_state.phase)
                PH_IDX_HI: o_status = ST_OK;
                PH_IDX_LO: o_status = ST_TRUNC_HDR;
                PH_SUBIDX: o_status = ST_TRUNC_HDR;
                PH_LEN:    o_status = ST_TRUNC_HDR;
                default:   o_status = ST_TRUNC_DATA;
            endcase
        end
    end

endmodule

FILE: src/record_image_checker_fletcher16_core.sv
// Record image checker top level: byte stream in, one check result per image out.
// Depends on ricf16_pkg and ricf16_step.
//
//  channel   dir  beat                 payload
//  s_axis    in   one image byte       tdata = image_byte, tlast = last_byte
//  m_axis    out  one result per image tdata = status, checksum, image_length, record_count
//
// One byte per cycle sustained while the result register is free for each image's result.
// Each byte is registered in the input register, then the single-pass update (two mod-255
// adds, framing, counters) writes the state and, on the last byte, the result register.
// A last byte waits there while the result register is full and unread, holding off
// the bytes behind it; otherwise the input never stalls.
// Synchronous active-low reset clears the stage valids and the running state.
module record_image_checker_fletcher16_core #(
    parameter int unsigned IMAGE_MAX_BYTES = ricf16_pkg::IMAGE_MAX_BYTES_DEF,
    parameter int unsigned LEN_W           = $clog2(IMAGE_MAX_BYTES + 1),
    parameter int unsigned OUT_BITS        = ricf16_pkg::STATUS_W + ricf16_pkg::CHECKSUM_W
                                             + LEN_W + ricf16_pkg::REC_W,
    parameter int unsigned OUT_W           = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] image_byte
    input  logic             s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // status, checksum, image_length,
                                             // record_count, zero fill
);
    import ricf16_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // running state
    t_state           r_state;
    logic [LEN_W-1:0] r_cnt;

    // result register
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    t_state           upd_state;
    logic [LEN_W-1:0] upd_cnt;
    t_status          upd_status;

    logic out_free;
    logic fire;

    ricf16_step #(
        .IMAGE_MAX_BYTES(IMAGE_MAX_BYTES),
        .LEN_W          (LEN_W)
    ) u_step (
        .i_state (r_state),
        .i_cnt   (r_cnt),
        .i_byte  (r_in_byte),
        .o_state (upd_state),
        .o_cnt   (upd_cnt),
        .o_status(upd_status)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    // A non-final byte never needs the result register.
    assign fire          = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_cnt   <= '0;
        end else if (fire) begin
            // the final byte of an image clears everything for the next one
            r_state <= r_in_last ? STATE_RESET : upd_state;
            r_cnt   <= r_in_last ? '0 : upd_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in_last) begin
            r_out_data <= OUT_W'({upd_state.records_seen, upd_cnt,
                                  upd_state.high_sum, upd_state.low_sum, upd_status});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: tb/record_image_checker_fletcher16_core_tb.sv
// Testbench for record_image_checker_fletcher16_core: streams record images byte by byte
// and checks every result beat against an in-bench model of framing and Fletcher-16 sums.
// Depends on ricf16_pkg and the core RTL only.
module record_image_checker_fletcher16_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ricf16_pkg::*;

    localparam int unsigned IMG_MAX  = IMAGE_MAX_BYTES_DEF;
    localparam int unsigned LEN_W    = $clog2(IMG_MAX + 1);
    localparam int unsigned OUT_BITS = STATUS_W + CHECKSUM_W + LEN_W + REC_W;
    localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Result beat layout, lowest bits first.
    localparam int unsigned ST_LO  = 0;
    localparam int unsigned CK_LO  = ST_LO + STATUS_W;
    localparam int unsigned LEN_LO = CK_LO + CHECKSUM_W;
    localparam int unsigned REC_LO = LEN_LO + LEN_W;

    localparam int unsigned RANDOM_BYTES = 500;
    localparam int unsigned DRAIN_EVERY  = 16;

    typedef struct {
        t_status          status;
        logic [15:0]      checksum;
        logic [LEN_W-1:0] length;
        logic [REC_W-1:0] records;
    } t_image_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata;   // [7:0] image_byte
    logic             s_axis_tlast;   // last_byte
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;   // [1:0] status, [17:2] checksum, [26:18] image_length,
                                      // [33:27] record_count, zero fill above

    record_image_checker_fletcher16_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 4 ns clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Model state: mirrors the running state of the core.
    logic [7:0]       sum_lo;
    logic [7:0]       sum_hi;
    t_phase           frame_phase;
    logic [7:0]       bytes_due;
    logic [LEN_W-1:0] byte_count;
    logic [REC_W-1:0] header_count;
    logic             too_long;

    t_image_result    pending_results[$];
    logic [7:0]       image_q[$];

    int unsigned      n_fail;
    int unsigned      n_bytes_sent;
    int unsigned      n_images_checked;
    bit               tx_idle_en;
    bit               rx_idle_en;
    int unsigned      rx_hold;

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------
    function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
        int unsigned s;
        s = int'(a) + int'(b);
        if (s >= 255) s -= 255;
        return 8'(s);
    endfunction

    task automatic clear_model();
        sum_lo       = '0;
        sum_hi       = '0;
        frame_phase  = PH_IDX_HI;
        bytes_due    = '0;
        byte_count   = '0;
        header_count = '0;
        too_long     = 1'b0;
    endtask

    // Fold one accepted byte into the model; queue a result on the last byte.
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        t_image_result r;
        sum_lo = add_mod255(sum_lo, b);
        sum_hi = add_mod255(sum_hi, sum_lo);

        // length saturates; any byte past the maximum marks the image too long
        if (byte_count < LEN_W'(IMG_MAX)) byte_count++;
        else too_long = 1'b1;

        case (frame_phase)
            PH_DATA: begin
                if (bytes_due != 0) bytes_due--;
                if (bytes_due == 0) frame_phase = PH_IDX_HI;
            end
            PH_LEN: begin
                bytes_due   = b;
                frame_phase = (b == 0) ? PH_IDX_HI : PH_DATA;
            end
            default: begin
                if (frame_phase == PH_IDX_HI && header_count < RECORDS_MAX) header_count++;
                frame_phase = t_phase'(frame_phase + 3'd1);
            end
        endcase

        if (last) begin
            // overlength wins over any framing fault
            if (too_long)                      r.status = ST_TOO_LONG;
            else if (frame_phase == PH_IDX_HI) r.status = ST_OK;
            else if (frame_phase == PH_DATA)   r.status = ST_TRUNC_DATA;
            else                               r.status = ST_TRUNC_HDR;
            r.checksum = {sum_hi, sum_lo};
            r.length   = byte_count;
            r.records  = header_count;
            pending_results.push_back(r);
            clear_model();
        end
    endtask

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap(input bit en);
        int unsigned r;
        if (!en) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Sender: called at a falling edge, returns at a falling edge with
    // tvalid still high so back-to-back beats need no drop.
    // ------------------------------------------------------------------
    task automatic push_image_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = pick_gap(tx_idle_en);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        absorb_byte(b, last);
        n_bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_image();
        for (int i = 0; i < image_q.size(); i++)
            push_image_byte(image_q[i], i == image_q.size() - 1);
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
    endtask

    // Idle the sender and hold off until every queued result has come out, then settle.
    task automatic drain_results();
        idle_sender();
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One record header plus data, random content.
    task automatic add_record(input logic [7:0] len);
        image_q.push_back(8'($urandom));
        image_q.push_back(8'($urandom));
        image_q.push_back(8'($urandom));
        image_q.push_back(len);
        repeat (len) image_q.push_back(8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls on the result side
    // ------------------------------------------------------------------
    initial m_axis_tready = 1'b0;
    initial rx_hold = 0;

    always @(negedge i_clk) begin
        if (rx_hold == 0) rx_hold = pick_gap(rx_idle_en);
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result beat against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_image_result    e;
        t_status          got_status;
        logic [15:0]      got_checksum;
        logic [LEN_W-1:0] got_length;
        logic [REC_W-1:0] got_records;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_status   = t_status'(m_axis_tdata[ST_LO +: STATUS_W]);
            got_checksum = m_axis_tdata[CK_LO +: CHECKSUM_W];
            got_length   = m_axis_tdata[LEN_LO +: LEN_W];
            got_records  = m_axis_tdata[REC_LO +: REC_W];
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: status %0d checksum %h length %0d records %0d",
                       got_status, got_checksum, got_length, got_records);
                n_fail++;
            end else begin
                e = pending_results.pop_front();
                n_images_checked++;
                if (got_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, got_status);
                    n_fail++;
                end
                if (got_checksum !== e.checksum) begin
                    $error("checksum: expected %h, got %h", e.checksum, got_checksum);
                    n_fail++;
                end
                if (got_length !== e.length) begin
                    $error("image_length: expected %0d, got %0d", e.length, got_length);
                    n_fail++;
                end
                if (got_records !== e.records) begin
                    $error("record_count: expected %0d, got %0d", e.records, got_records);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short images hitting each framing outcome and the byte extremes.
    task automatic test_framing();
        image_q = '{8'h00};                                   // ends in index high
        send_image();
        image_q = '{8'hFF, 8'hFF};                            // ends in index low
        send_image();
        image_q = '{8'h01, 8'h02, 8'h03, 8'h00};              // empty record, ok
        send_image();
        image_q = '{8'hFF, 8'h00, 8'hFF, 8'h02, 8'hFF, 8'h00}; // record with data, ok
        send_image();
        image_q = '{8'h10, 8'h20, 8'h01, 8'h05};              // ends on nonzero length
        send_image();
        image_q = '{8'hAA, 8'h55, 8'h00, 8'h03, 8'h01, 8'h02}; // ends inside data
        send_image();
        image_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h7F}; // second header begun
        send_image();
    endtask

    // Exactly the maximum size, then one byte over.
    task automatic test_max_length();
        image_q.delete();
        repeat (IMG_MAX / 16) add_record(8'd12);
        send_image();
        image_q.delete();
        repeat (IMG_MAX / 16) add_record(8'd12);
        image_q.push_back(8'($urandom));
        send_image();
    endtask

    // Enough empty records that the header count saturates (image is overlength too).
    task automatic test_record_saturation();
        image_q.delete();
        repeat (int'(RECORDS_MAX) + 3) begin
            image_q.push_back(8'($urandom));
            image_q.push_back(8'($urandom));
            image_q.push_back(8'($urandom));
            image_q.push_back(8'h00);
        end
        send_image();
        drain_results();
    endtask

    task automatic build_random_image();
        int unsigned kind;
        int unsigned n_rec;
        int unsigned keep;
        logic [7:0]  len;
        image_q.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 7) begin
            n_rec = $urandom_range(1, 6);
            repeat (n_rec) begin
                len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 60))
                                                  : 8'($urandom_range(0, 6));
                add_record(len);
            end
            // broken frame: cut it short anywhere
            if (kind == 7 && image_q.size() > 1) begin
                keep = $urandom_range(1, image_q.size() - 1);
                while (image_q.size() > keep) void'(image_q.pop_back());
            end
        end else begin
            // raw noise, short or around the size limit
            keep = (kind == 8) ? $urandom_range(1, 20) : $urandom_range(IMG_MAX - 6, IMG_MAX + 14);
            repeat (keep) image_q.push_back(8'($urandom));
        end
    endtask

    // Mostly well-formed images with random content; some truncated, some noise.
    task automatic test_random_images();
        int unsigned start;
        int unsigned n_img;
        start = n_bytes_sent;
        n_img = 0;
        while (n_bytes_sent - start < RANDOM_BYTES) begin
            // a stretch of back-to-back traffic with no idling on either side
            tx_idle_en = !(n_img >= 10 && n_img < 20);
            rx_idle_en = tx_idle_en;
            build_random_image();
            send_image();
            n_img++;
            if (n_img % DRAIN_EVERY == 0) drain_results();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        n_fail           = 0;
        n_bytes_sent     = 0;
        n_images_checked = 0;
        tx_idle_en       = 1'b1;
        rx_idle_en       = 1'b1;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tlast     = 1'b0;
        i_rst_n          = 1'b0;
        clear_model();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_framing();
        test_max_length();
        test_record_saturation();   // includes a full drain with the sender held off
        test_random_images();

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes, checked %0d images: every framing outcome, size limit,",
                 n_bytes_sent, n_images_checked);
        $display("header count saturation, random images with stalls on both sides.");
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
